// ----- hw/rtl/robot_opponent_chase_controller_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the opponent chase controller
// Clocked concurrent checks with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ROBOT_OPPONENT_CHASE_CONTROLLER_MACROS_SVH
`define ROBOT_OPPONENT_CHASE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// check gated off while reset is high
`define ROC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("roc assertion failed");

// check that also holds during reset
`define ROC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("roc assertion failed");

`else

`define ROC_ASSERT(lbl, prop)
`define ROC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- hw/rtl/roc_pkg.sv -----
// ----------------------------------------------------------------------------
// roc_pkg
// Types, codes and reset values shared by the chase controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package roc_pkg;

   localparam int WINDOW_DEPTH = 8;
   localparam int CM_W         = 10;

   localparam logic [CM_W-1:0] WINDOW_INIT = 10'd1000;

   // configuration register indexes
   localparam logic [2:0] CSR_DROP_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_NEAR_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_CONFIRM_NEEDED = 3'd2;
   localparam logic [2:0] CSR_AVOID_TIME_MS  = 3'd3;
   localparam logic [2:0] CSR_NO_ECHO_CODE   = 3'd4;

   // configuration reset values
   localparam logic [9:0]  RST_DROP_THRESHOLD = 10'd30;
   localparam logic [9:0]  RST_NEAR_THRESHOLD = 10'd20;
   localparam logic [3:0]  RST_CONFIRM_NEEDED = 4'd2;
   localparam logic [15:0] RST_AVOID_TIME_MS  = 16'd4000;
   localparam logic [9:0]  RST_NO_ECHO_CODE   = 10'd1023;

   // drive directions
   localparam logic [2:0] DIR_FORWARD = 3'd0;
   localparam logic [2:0] DIR_REVERSE = 3'd1;
   localparam logic [2:0] DIR_LEFT    = 3'd2;
   localparam logic [2:0] DIR_RIGHT   = 3'd3;
   localparam logic [2:0] DIR_CW      = 3'd4;
   localparam logic [2:0] DIR_CCW     = 3'd5;

   // reported mode codes
   localparam logic [1:0] MODE_STARTUP = 2'd0;
   localparam logic [1:0] MODE_SEARCH  = 2'd1;
   localparam logic [1:0] MODE_CHASE   = 2'd2;
   localparam logic [1:0] MODE_AVOID   = 2'd3;

   localparam logic [3:0] CONFIRM_MAX = 4'd15;

   typedef struct packed {
      logic [9:0]  left_cm;
      logic [9:0]  right_cm;
      logic        front_left_line;
      logic        front_right_line;
      logic        rear_left_line;
      logic        rear_right_line;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] drive_dir;
      logic [1:0] mode;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  drop_threshold;
      logic [9:0]  near_threshold;
      logic [3:0]  confirm_needed;
      logic [15:0] avoid_time_ms;
      logic [9:0]  no_echo_code;
   } cfg_type;

   // window status after the current push
   typedef struct packed {
      logic            full;
      logic [CM_W-1:0] mean;
   } win_stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/roc_ram.sv -----
// ----------------------------------------------------------------------------
// roc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module roc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/roc_window.sv -----
// ----------------------------------------------------------------------------
// roc_window
// Sliding window of range means with running sum and constant divide.
// ----------------------------------------------------------------------------
`default_nettype none

`include "robot_opponent_chase_controller_macros.svh"

module roc_window #(
   parameter int DEPTH = roc_pkg::WINDOW_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic [roc_pkg::CM_W-1:0] value,
   output roc_pkg::win_stat_type         stat
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int SUM_W   = roc_pkg::CM_W + PTR_W;
   localparam int SHIFT   = SUM_W + PTR_W;
   localparam int MAGIC_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + MAGIC_W;
   // ceil(2^SHIFT / DEPTH): exact floor divide for any SUM_W-bit sum
   localparam longint unsigned MAGIC = ((64'd1 << SHIFT) + DEPTH - 1) / DEPTH;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [SUM_W-1:0] SUM_INIT = SUM_W'(int'(roc_pkg::WINDOW_INIT) * DEPTH);

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             full_ff, full_in;

   logic [roc_pkg::CM_W-1:0] rd_data;
   logic [roc_pkg::CM_W-1:0] old_value;
   logic [SUM_W-1:0]         push_sum;
   logic [PROD_W-1:0]        prod;
   logic                     wrap;

   roc_ram #(
      .WIDTH (roc_pkg::CM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (ptr_ff),
      .wr_data (value),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   // read data always holds the entry at ptr_ff; unwritten until first wrap
   assign old_value = full_ff ? rd_data : roc_pkg::WINDOW_INIT;
   assign wrap      = (ptr_ff == LAST_PTR);
   assign push_sum  = sum_ff - SUM_W'(old_value) + SUM_W'(value);

   always_comb begin
      ptr_in  = ptr_ff;
      sum_in  = sum_ff;
      full_in = full_ff;
      if (push) begin
         ptr_in  = wrap ? '0 : ptr_ff + 1'b1;
         sum_in  = push_sum;
         full_in = full_ff | wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         sum_ff  <= SUM_INIT;
         full_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         sum_ff  <= sum_in;
         full_ff <= full_in;
      end
   end

   assign prod      = PROD_W'(push_sum) * PROD_W'(MAGIC);
   assign stat.mean = prod[SHIFT +: roc_pkg::CM_W];
   assign stat.full = full_ff | wrap;

   `ROC_ASSERT(a_ptr_in_range, ptr_ff <= LAST_PTR)
   `ROC_ASSERT(a_full_sticky, $past(full_ff) && !$past(reset) |-> full_ff)

endmodule

`default_nettype wire

// ----- hw/rtl/roc_fsm.sv -----
// ----------------------------------------------------------------------------
// roc_fsm
// Mode machine, confirm counter and drive direction selection.
// ----------------------------------------------------------------------------
`default_nettype none

`include "robot_opponent_chase_controller_macros.svh"

module roc_fsm (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire roc_pkg::req_type         req,
   input  wire logic [roc_pkg::CM_W-1:0] newest,
   input  wire roc_pkg::cfg_type         cfg,
   input  wire roc_pkg::win_stat_type    win,
   output roc_pkg::rsp_type              rsp
);

   typedef enum logic [3:0] {
      ST_STARTUP = 4'b0001,
      ST_SEARCH  = 4'b0010,
      ST_CHASE   = 4'b0100,
      ST_AVOID   = 4'b1000
   } mode_state_type;

   mode_state_type mode_ff, mode_in;
   logic [3:0]     confirm_ff, confirm_in;
   logic [2:0]     last_dir_ff, last_dir_in;
   logic [31:0]    avoid_start_ff, avoid_start_in;

   logic        line;
   logic [11:0] drop_diff;
   logic        drop;
   logic [3:0]  confirm_det;
   logic        detected;
   logic        both_echo;
   logic        none_echo;
   logic        left_nearer;
   logic        right_nearer;
   logic [31:0] elapsed;
   logic        avoid_done;
   logic [2:0]  dir;

   assign line = req.front_left_line | req.front_right_line
               | req.rear_left_line  | req.rear_right_line;

   // signed compare: mean - newest > drop_threshold
   assign drop_diff = {2'b00, win.mean} - {2'b00, newest};
   assign drop      = ($signed(drop_diff) > $signed({2'b00, cfg.drop_threshold}))
                    || (newest < cfg.near_threshold);

   always_comb begin
      if (drop) begin
         confirm_det = (confirm_ff == roc_pkg::CONFIRM_MAX) ? confirm_ff
                                                            : confirm_ff + 1'b1;
      end else begin
         confirm_det = (confirm_ff == '0) ? confirm_ff : confirm_ff - 1'b1;
      end
   end

   assign detected = win.full && (confirm_det >= cfg.confirm_needed);

   assign both_echo    = (req.left_cm != cfg.no_echo_code)
                       && (req.right_cm != cfg.no_echo_code);
   assign none_echo    = (req.left_cm == cfg.no_echo_code)
                       && (req.right_cm == cfg.no_echo_code);
   assign left_nearer  = ({1'b0, req.left_cm} + {1'b0, cfg.near_threshold})
                       < {1'b0, req.right_cm};
   assign right_nearer = ({1'b0, req.right_cm} + {1'b0, cfg.near_threshold})
                       < {1'b0, req.left_cm};

   assign elapsed    = req.now_ms - avoid_start_ff;
   assign avoid_done = elapsed > {16'd0, cfg.avoid_time_ms};

   always_comb begin
      mode_in        = mode_ff;
      confirm_in     = confirm_ff;
      last_dir_in    = last_dir_ff;
      avoid_start_in = avoid_start_ff;
      dir            = roc_pkg::DIR_FORWARD;
      unique case (mode_ff)
         ST_STARTUP: begin
            dir = roc_pkg::DIR_CW;
            if (win.full) begin
               confirm_in = detected ? '0 : confirm_det;
               if (detected) begin
                  mode_in = ST_CHASE;
               end
            end
         end
         ST_SEARCH: begin
            dir = last_dir_ff;
            if (line) begin
               mode_in        = ST_AVOID;
               avoid_start_in = req.now_ms;
            end else if (win.full) begin
               confirm_in = detected ? '0 : confirm_det;
               if (detected) begin
                  mode_in = ST_CHASE;
               end
            end
         end
         ST_CHASE: begin
            if (both_echo && left_nearer) begin
               dir         = roc_pkg::DIR_LEFT;
               last_dir_in = roc_pkg::DIR_LEFT;
            end else if (both_echo && right_nearer) begin
               dir         = roc_pkg::DIR_RIGHT;
               last_dir_in = roc_pkg::DIR_RIGHT;
            end
            if (line) begin
               mode_in        = ST_AVOID;
               avoid_start_in = req.now_ms;
            end else if (none_echo) begin
               mode_in = ST_SEARCH;
            end
         end
         ST_AVOID: begin
            priority if (req.front_left_line || req.front_right_line) begin
               dir = roc_pkg::DIR_REVERSE;
            end else if (req.rear_left_line && req.rear_right_line) begin
               dir = roc_pkg::DIR_FORWARD;
            end else if (req.rear_left_line) begin
               dir = roc_pkg::DIR_RIGHT;
            end else if (req.rear_right_line) begin
               dir = roc_pkg::DIR_LEFT;
            end else begin
               dir = roc_pkg::DIR_CW;
            end
            if (avoid_done) begin
               mode_in        = ST_SEARCH;
               avoid_start_in = req.now_ms;
            end
         end
         default: begin
            mode_in = ST_STARTUP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ST_STARTUP;
         confirm_ff     <= '0;
         last_dir_ff    <= roc_pkg::DIR_CCW;
         avoid_start_ff <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         confirm_ff     <= confirm_in;
         last_dir_ff    <= last_dir_in;
         avoid_start_ff <= avoid_start_in;
      end
   end

   always_comb begin
      unique case (mode_in)
         ST_STARTUP: rsp.mode = roc_pkg::MODE_STARTUP;
         ST_SEARCH:  rsp.mode = roc_pkg::MODE_SEARCH;
         ST_CHASE:   rsp.mode = roc_pkg::MODE_CHASE;
         ST_AVOID:   rsp.mode = roc_pkg::MODE_AVOID;
         default:    rsp.mode = roc_pkg::MODE_STARTUP;
      endcase
   end

   assign rsp.drive_dir = dir;

   // a fresh chase always starts with a cleared confirm count
   `ROC_ASSERT(a_chase_entry_clear,
      mode_ff == ST_CHASE && $past(mode_ff) != ST_CHASE && !$past(reset)
      |-> confirm_ff == '0)

endmodule

`default_nettype wire

// ----- hw/rtl/robot_opponent_chase_controller.sv -----
// ----------------------------------------------------------------------------
// robot_opponent_chase_controller
// Sumo robot opponent detection and drive direction controller.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sensor sample per request (ranges, line flags, time stamp).
//            Taken on a clock edge with req_valid high and req_stall low.
//   rsp_*  : one drive direction and mode per request, in request order.
//   csr_*  : register writes, index 0..4; csr_ready is always high, other
//            indexes are dropped. Write only while no request is in flight.
// From request accept to rsp_valid, the request sits in the input register,
// then the window update, divide and mode logic load the result register.
// Throughput is one request per cycle while rsp_stall is low; the running
// window sum and one constant-reciprocal multiply keep a step short.
// If rsp_stall holds a full result register, the input register holds its
// request and req_stall rises until the result is taken.
// Reset clears the mode machine, confirm count and window fill state; the
// window reads as 1000 cm until its first full lap. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "robot_opponent_chase_controller_macros.svh"

module robot_opponent_chase_controller #(
   parameter int WINDOW_DEPTH = roc_pkg::WINDOW_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire roc_pkg::req_type req_payload,

   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output roc_pkg::rsp_type      rsp_payload,

   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   roc_pkg::cfg_type cfg_ff;

   logic             s1_valid_ff;
   roc_pkg::req_type s1_data_ff;
   logic             out_valid_ff;
   roc_pkg::rsp_type out_data_ff;

   logic                     s1_adv;
   logic                     req_accept;
   logic [10:0]              range_sum;
   logic [roc_pkg::CM_W-1:0] newest;
   roc_pkg::win_stat_type    win_stat;
   roc_pkg::rsp_type         step_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_threshold <= roc_pkg::RST_DROP_THRESHOLD;
         cfg_ff.near_threshold <= roc_pkg::RST_NEAR_THRESHOLD;
         cfg_ff.confirm_needed <= roc_pkg::RST_CONFIRM_NEEDED;
         cfg_ff.avoid_time_ms  <= roc_pkg::RST_AVOID_TIME_MS;
         cfg_ff.no_echo_code   <= roc_pkg::RST_NO_ECHO_CODE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            roc_pkg::CSR_DROP_THRESHOLD: cfg_ff.drop_threshold <= csr_wdata[9:0];
            roc_pkg::CSR_NEAR_THRESHOLD: cfg_ff.near_threshold <= csr_wdata[9:0];
            roc_pkg::CSR_CONFIRM_NEEDED: cfg_ff.confirm_needed <= csr_wdata[3:0];
            roc_pkg::CSR_AVOID_TIME_MS:  cfg_ff.avoid_time_ms  <= csr_wdata;
            roc_pkg::CSR_NO_ECHO_CODE:   cfg_ff.no_echo_code   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_payload;
      end
      if (s1_adv) begin
         out_data_ff <= step_rsp;
      end
   end

   assign range_sum = {1'b0, s1_data_ff.left_cm} + {1'b0, s1_data_ff.right_cm};
   assign newest    = range_sum[10:1];

   roc_window #(
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .push  (s1_adv),
      .value (newest),
      .stat  (win_stat)
   );

   roc_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_adv),
      .req    (s1_data_ff),
      .newest (newest),
      .cfg    (cfg_ff),
      .win    (win_stat),
      .rsp    (step_rsp)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   `ROC_ASSERT_ALWAYS(a_stall_cause, req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
   `ROC_ASSERT(a_held_request_kept,
      $past(s1_valid_ff && !s1_adv) && !$past(reset) |-> s1_valid_ff)

endmodule

`default_nettype wire
